// File: hdl/pse_pkg.sv
`timescale 1ns / 1ps
package pse_pkg;

   localparam int ADDR_WIDTH      = 48;
   localparam int CHAR_WIDTH      = 7;
   localparam int BYTE_WIDTH      = 8;
   localparam int COUNT_WIDTH     = 4;
   localparam int CFG_WIDTH       = 4;
   localparam int CSR_INDEX_WIDTH = 1;

   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = 4'd15;
   localparam logic [CFG_WIDTH-1:0]   CFG_RESET = 4'd4;

   localparam logic [BYTE_WIDTH-1:0] PRINT_LO = 8'h20;
   localparam logic [BYTE_WIDTH-1:0] PRINT_HI = 8'h7E;

   localparam logic KIND_ASCII = 1'b0;
   localparam logic KIND_WIDE  = 1'b1;
   localparam logic REC_CHAR   = 1'b0;
   localparam logic REC_END    = 1'b1;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MIN_ASCII = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MIN_WIDE  = 1'b1;

   typedef struct packed {
      logic [BYTE_WIDTH-1:0] byte_value;
      logic [ADDR_WIDTH-1:0] byte_address;
      logic                  region_last;
   } req_type;

   typedef struct packed {
      logic                  string_kind;
      logic                  record_type;
      logic [ADDR_WIDTH-1:0] start_address;
      logic [CHAR_WIDTH-1:0] char_code;
      logic                  last_of_item;
   } rsp_type;

   function automatic logic is_printable(input logic [BYTE_WIDTH-1:0] v);
      return (v >= PRINT_LO) && (v <= PRINT_HI);
   endfunction

endpackage

// File: hdl/printable_string_extractor_core.sv
`timescale 1ns / 1ps
// Printable string extractor. Bytes of a memory region enter on the req_ side, one word per
// cycle while req_full is low; ASCII runs (0x20..0x7E) and UTF-16LE runs paired from the region
// start are tracked side by side, and each string leaves on the rsp_ side as character words
// followed by an end word holding its start address. The front classifies a byte in the cycle
// it is taken and queues a short command (QUEUE_DEPTH entries); the back expands each command
// into its records at one rsp_ word per cycle while rsp_ words are popped, the two sides
// working in parallel. A byte causes usually zero to two records, up to 2*(MAX_MIN_LENGTH+1)
// (buffered characters, the current one and an end word per detector) when both detectors
// reach their minimum on the same byte; the queue absorbs such bursts, so the sustained rate
// is set by the slower side.
// No clearing pass is needed after reset. min lengths: csr index 0 ASCII, 1 wide, 4 bits
// each, reset 4.
module printable_string_extractor_core
   import pse_pkg::*;
#(
   parameter int MAX_MIN_LENGTH = 8,
   parameter int QUEUE_DEPTH    = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CFG_WIDTH-1:0]       csr_write_data,
   input  logic                       req_push,
   input  req_type                    req_data,
   output logic                       req_full,
   output logic                       rsp_empty,
   input  logic                       rsp_pop,
   output rsp_type                    rsp_data
);

   localparam int SLOTS    = 2 * (MAX_MIN_LENGTH + 2);
   localparam int CMD_BITS = SLOTS + 2 * ADDR_WIDTH + 2 * CHAR_WIDTH
                             + 2 * MAX_MIN_LENGTH * CHAR_WIDTH;

   logic accept, cmd_push, q_full, q_empty, q_pop;
   logic [SLOTS-1:0]                          f_mask, b_mask;
   logic [ADDR_WIDTH-1:0]                     f_a_start, f_w_start, b_a_start, b_w_start;
   logic [CHAR_WIDTH-1:0]                     f_a_char, f_w_char, b_a_char, b_w_char;
   logic [MAX_MIN_LENGTH-1:0][CHAR_WIDTH-1:0] f_a_pend, f_w_pend, b_a_pend, b_w_pend;
   logic [CMD_BITS-1:0]                       q_in, q_out;

   assign req_full = q_full;
   assign accept   = req_push && !q_full;

   pse_front #(.MAX_MIN_LENGTH(MAX_MIN_LENGTH)) u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .accept           (accept),
      .req_data         (req_data),
      .cmd_push         (cmd_push),
      .cmd_mask         (f_mask),
      .cmd_a_start      (f_a_start),
      .cmd_w_start      (f_w_start),
      .cmd_a_char       (f_a_char),
      .cmd_w_char       (f_w_char),
      .cmd_a_pend       (f_a_pend),
      .cmd_w_pend       (f_w_pend)
   );

   assign q_in = {f_mask, f_a_start, f_w_start, f_a_char, f_w_char, f_a_pend, f_w_pend};

   pse_fifo #(.WIDTH(CMD_BITS), .DEPTH(QUEUE_DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (q_in),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_out),
      .empty     (q_empty)
   );

   assign {b_mask, b_a_start, b_w_start, b_a_char, b_w_char, b_a_pend, b_w_pend} = q_out;

   pse_back #(.MAX_MIN_LENGTH(MAX_MIN_LENGTH)) u_back (
      .clock       (clock),
      .reset       (reset),
      .cmd_valid   (!q_empty),
      .cmd_pop     (q_pop),
      .cmd_mask    (b_mask),
      .cmd_a_start (b_a_start),
      .cmd_w_start (b_w_start),
      .cmd_a_char  (b_a_char),
      .cmd_w_char  (b_w_char),
      .cmd_a_pend  (b_a_pend),
      .cmd_w_pend  (b_w_pend),
      .rsp_pop     (rsp_pop),
      .rsp_empty   (rsp_empty),
      .rsp_data    (rsp_data)
   );

endmodule

// File: hdl/pse_fifo.sv
`timescale 1ns / 1ps
module pse_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PTR_WIDTH = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_WIDTH = $clog2(DEPTH + 1);
   localparam logic [PTR_WIDTH-1:0] PTR_LAST = PTR_WIDTH'(DEPTH - 1);
   localparam logic [CNT_WIDTH-1:0] CNT_FULL = CNT_WIDTH'(DEPTH);

   logic [WIDTH-1:0]     slot_ff [DEPTH];
   logic [PTR_WIDTH-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_WIDTH-1:0] count_ff;
   logic                 do_push, do_pop;

   assign full     = (count_ff == CNT_FULL);
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: hdl/pse_front.sv
`timescale 1ns / 1ps
module pse_front
   import pse_pkg::*;
#(
   parameter int MAX_MIN_LENGTH = 8
) (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic                                         csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0]                   csr_index,
   input  logic [CFG_WIDTH-1:0]                         csr_write_data,
   input  logic                                         accept,
   input  req_type                                      req_data,
   output logic                                         cmd_push,
   output logic [2*(MAX_MIN_LENGTH+2)-1:0]              cmd_mask,
   output logic [ADDR_WIDTH-1:0]                        cmd_a_start,
   output logic [ADDR_WIDTH-1:0]                        cmd_w_start,
   output logic [CHAR_WIDTH-1:0]                        cmd_a_char,
   output logic [CHAR_WIDTH-1:0]                        cmd_w_char,
   output logic [MAX_MIN_LENGTH-1:0][CHAR_WIDTH-1:0]    cmd_a_pend,
   output logic [MAX_MIN_LENGTH-1:0][CHAR_WIDTH-1:0]    cmd_w_pend
);

   localparam logic [COUNT_WIDTH:0] MIN_CAP = (COUNT_WIDTH + 1)'(MAX_MIN_LENGTH);

   logic [CFG_WIDTH-1:0]   min_ascii_ff, min_wide_ff;
   logic [COUNT_WIDTH-1:0] a_count_ff, a_count_in, w_count_ff, w_count_in;
   logic [ADDR_WIDTH-1:0]  a_start_ff, a_start_in, w_start_ff, w_start_in;
   logic [BYTE_WIDTH-1:0]  low_byte_ff, low_byte_in;
   logic [ADDR_WIDTH-1:0]  low_addr_ff, low_addr_in;
   logic                   phase_ff, phase_in;
   logic [MAX_MIN_LENGTH-1:0][CHAR_WIDTH-1:0] a_pend_ff, w_pend_ff;

   logic [COUNT_WIDTH-1:0]    a_min, w_min, a_now, w_now;
   logic                      a_print, w_print, a_write, w_write;
   logic [MAX_MIN_LENGTH-1:0] a_flush, w_flush;
   logic                      a_chr, a_end, w_chr, w_end;

   function automatic logic [COUNT_WIDTH-1:0] eff_min(input logic [CFG_WIDTH-1:0] v);
      logic [COUNT_WIDTH-1:0] r;
      r = v;
      if (r == '0) r = COUNT_WIDTH'(1);
      if ({1'b0, r} > MIN_CAP) r = COUNT_WIDTH'(MAX_MIN_LENGTH);
      return r;
   endfunction

   // pending entries 0..old-1 go out on a flush
   function automatic logic [MAX_MIN_LENGTH-1:0] flush_bits(input logic [COUNT_WIDTH-1:0] old);
      logic [MAX_MIN_LENGTH-1:0] f;
      for (int k = 0; k < MAX_MIN_LENGTH; k++) begin
         f[k] = ({1'b0, old} > (COUNT_WIDTH + 1)'(k));
      end
      return f;
   endfunction

   always_comb begin
      a_min   = eff_min(min_ascii_ff);
      w_min   = eff_min(min_wide_ff);
      a_print = is_printable(req_data.byte_value);
      w_print = (req_data.byte_value == '0) && is_printable(low_byte_ff);
      a_now   = (a_count_ff == COUNT_MAX) ? a_count_ff : a_count_ff + 1'b1;
      w_now   = (w_count_ff == COUNT_MAX) ? w_count_ff : w_count_ff + 1'b1;

      a_count_in = a_count_ff;
      a_start_in = a_start_ff;
      a_flush    = '0;
      a_chr      = 1'b0;
      a_end      = 1'b0;
      a_write    = 1'b0;
      if (a_print) begin
         a_write = 1'b1;
         if (a_count_ff == '0) a_start_in = req_data.byte_address;
         if (a_now == a_min && a_count_ff < a_now) begin
            a_flush = flush_bits(a_count_ff);
            a_chr   = 1'b1;
         end else if (a_now > a_min) begin
            a_chr = 1'b1;
         end
         if (req_data.region_last) begin
            a_end      = (a_now >= a_min);
            a_count_in = '0;
         end else begin
            a_count_in = a_now;
         end
      end else begin
         a_end      = (a_count_ff >= a_min);
         a_count_in = '0;
      end

      w_count_in  = w_count_ff;
      w_start_in  = w_start_ff;
      low_byte_in = low_byte_ff;
      low_addr_in = low_addr_ff;
      phase_in    = phase_ff;
      w_flush     = '0;
      w_chr       = 1'b0;
      w_end       = 1'b0;
      w_write     = 1'b0;
      if (!phase_ff) begin
         if (req_data.region_last) begin
            // odd trailing byte: dropped, but it closes the wide run
            w_end      = (w_count_ff >= w_min);
            w_count_in = '0;
         end else begin
            low_byte_in = req_data.byte_value;
            low_addr_in = req_data.byte_address;
            phase_in    = 1'b1;
         end
      end else begin
         phase_in = 1'b0;
         if (w_print) begin
            w_write = 1'b1;
            if (w_count_ff == '0) w_start_in = low_addr_ff;
            if (w_now == w_min && w_count_ff < w_now) begin
               w_flush = flush_bits(w_count_ff);
               w_chr   = 1'b1;
            end else if (w_now > w_min) begin
               w_chr = 1'b1;
            end
            if (req_data.region_last) begin
               w_end      = (w_now >= w_min);
               w_count_in = '0;
            end else begin
               w_count_in = w_now;
            end
         end else begin
            w_end      = (w_count_ff >= w_min);
            w_count_in = '0;
         end
      end
   end

   assign cmd_mask    = {w_end, w_chr, w_flush, a_end, a_chr, a_flush};
   assign cmd_push    = accept && (cmd_mask != '0);
   assign cmd_a_start = a_start_in;
   assign cmd_w_start = w_start_in;
   assign cmd_a_char  = req_data.byte_value[CHAR_WIDTH-1:0];
   assign cmd_w_char  = low_byte_ff[CHAR_WIDTH-1:0];
   assign cmd_a_pend  = a_pend_ff;
   assign cmd_w_pend  = w_pend_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ascii_ff <= CFG_RESET;
         min_wide_ff  <= CFG_RESET;
         a_count_ff   <= '0;
         a_start_ff   <= '0;
         w_count_ff   <= '0;
         w_start_ff   <= '0;
         low_byte_ff  <= '0;
         low_addr_ff  <= '0;
         phase_ff     <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            unique case (csr_index)
               CSR_MIN_ASCII: min_ascii_ff <= csr_write_data;
               CSR_MIN_WIDE:  min_wide_ff  <= csr_write_data;
               default: ;
            endcase
         end
         if (accept) begin
            a_count_ff  <= a_count_in;
            a_start_ff  <= a_start_in;
            w_count_ff  <= w_count_in;
            w_start_ff  <= w_start_in;
            low_byte_ff <= low_byte_in;
            low_addr_ff <= low_addr_in;
            phase_ff    <= phase_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < MAX_MIN_LENGTH; k++) begin
         if (accept && a_write && ({1'b0, a_count_ff} == (COUNT_WIDTH + 1)'(k))) begin
            a_pend_ff[k] <= req_data.byte_value[CHAR_WIDTH-1:0];
         end
         if (accept && w_write && ({1'b0, w_count_ff} == (COUNT_WIDTH + 1)'(k))) begin
            w_pend_ff[k] <= low_byte_ff[CHAR_WIDTH-1:0];
         end
      end
   end

endmodule

// File: hdl/pse_back.sv
`timescale 1ns / 1ps
module pse_back
   import pse_pkg::*;
#(
   parameter int MAX_MIN_LENGTH = 8
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      cmd_valid,
   output logic                                      cmd_pop,
   input  logic [2*(MAX_MIN_LENGTH+2)-1:0]           cmd_mask,
   input  logic [ADDR_WIDTH-1:0]                     cmd_a_start,
   input  logic [ADDR_WIDTH-1:0]                     cmd_w_start,
   input  logic [CHAR_WIDTH-1:0]                     cmd_a_char,
   input  logic [CHAR_WIDTH-1:0]                     cmd_w_char,
   input  logic [MAX_MIN_LENGTH-1:0][CHAR_WIDTH-1:0] cmd_a_pend,
   input  logic [MAX_MIN_LENGTH-1:0][CHAR_WIDTH-1:0] cmd_w_pend,
   input  logic                                      rsp_pop,
   output logic                                      rsp_empty,
   output rsp_type                                   rsp_data
);

   localparam int SLOTS_PER = MAX_MIN_LENGTH + 2;
   localparam int SLOTS     = 2 * SLOTS_PER;

   logic [SLOTS-1:0]                          mask_ff, mask_left, sel;
   logic [ADDR_WIDTH-1:0]                     a_start_ff, w_start_ff;
   logic [CHAR_WIDTH-1:0]                     a_char_ff, w_char_ff;
   logic [MAX_MIN_LENGTH-1:0][CHAR_WIDTH-1:0] a_pend_ff, w_pend_ff;
   logic                                      out_valid_ff, out_free, emit;
   rsp_type                                   rsp_ff, record;

   assign out_free  = !out_valid_ff || rsp_pop;
   assign emit      = (mask_ff != '0) && out_free;
   assign sel       = mask_ff & (~mask_ff + 1'b1);   // lowest pending slot
   assign mask_left = emit ? (mask_ff & ~sel) : mask_ff;
   assign cmd_pop   = (mask_left == '0) && cmd_valid;
   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = rsp_ff;

   // slot order per word: buffered chars, current char, end record; ASCII first
   always_comb begin
      record               = '0;
      record.last_of_item  = (mask_left == '0);
      record.start_address = sel[SLOTS-1:SLOTS_PER] != '0 ? w_start_ff : a_start_ff;
      for (int d = 0; d < 2; d++) begin
         for (int j = 0; j < SLOTS_PER; j++) begin
            if (sel[d*SLOTS_PER + j]) begin
               record.string_kind = (d == 0) ? KIND_ASCII : KIND_WIDE;
               if (j < MAX_MIN_LENGTH) begin
                  record.record_type = REC_CHAR;
                  record.char_code   = (d == 0) ? a_pend_ff[j] : w_pend_ff[j];
               end else if (j == MAX_MIN_LENGTH) begin
                  record.record_type = REC_CHAR;
                  record.char_code   = (d == 0) ? a_char_ff : w_char_ff;
               end else begin
                  record.record_type = REC_END;
                  record.char_code   = '0;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         mask_ff      <= '0;
      end else begin
         if (emit) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_pop) begin
            out_valid_ff <= 1'b0;
         end
         mask_ff <= cmd_pop ? cmd_mask : mask_left;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_ff <= record;
      end
      if (cmd_pop) begin
         a_start_ff <= cmd_a_start;
         w_start_ff <= cmd_w_start;
         a_char_ff  <= cmd_a_char;
         w_char_ff  <= cmd_w_char;
         a_pend_ff  <= cmd_a_pend;
         w_pend_ff  <= cmd_w_pend;
      end
   end

   // the front never queues a word that yields no records
   a_no_empty_cmd: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> (cmd_mask != '0))
      else $error("queued word with no records");

   // a blocked record keeps its slot set
   a_hold_when_blocked: assert property (@(posedge clock) disable iff (reset)
      (mask_ff != '0) && out_valid_ff && !rsp_pop |=> $stable(mask_ff))
      else $error("slot mask moved while output blocked");

   // each emitted record retires exactly one slot
   a_one_slot: assert property (@(posedge clock) disable iff (reset)
      emit |-> ($countones(mask_ff) == $countones(mask_left) + 1))
      else $error("emit did not retire one slot");

   // next word is only taken once the current one has finished
   a_load_when_done: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> (!emit ? (mask_ff == '0) : ($countones(mask_ff) == 1)))
      else $error("word loaded over unfinished records");

endmodule
